// ----- src/lpms_pkg.sv -----
package lpms_pkg;

  localparam int MaxFramesDef = 16;
  localparam int MaxProcsDef  = 16;

  localparam int CmdW    = 1;
  localparam int ProcW   = 4;
  localparam int AmountW = 20;
  localparam int StatusW = 3;
  localparam int AddrW   = 24;
  localparam int PageW   = 16;
  localparam int FrameW  = 4;
  localparam int CountW  = 16;
  localparam int PsW     = 16;
  localparam int FcW     = 5;

  localparam logic [CmdW-1:0] CmdDefine = 1'b0;
  localparam logic [CmdW-1:0] CmdAccess = 1'b1;

  localparam logic [StatusW-1:0] StDefined  = 3'd0;
  localparam logic [StatusW-1:0] StHit      = 3'd1;
  localparam logic [StatusW-1:0] StFaultNew = 3'd2;
  localparam logic [StatusW-1:0] StFaultEv  = 3'd3;
  localparam logic [StatusW-1:0] StInvalid  = 3'd4;
  localparam logic [StatusW-1:0] StBadProc  = 3'd5;

  localparam logic [0:0] RegPageSize   = 1'b0;
  localparam logic [0:0] RegFrameCount = 1'b1;

  // per-cell status toward the controller
  typedef struct packed {
    logic             used;
    logic [PageW-1:0] page;
  } lpms_cell_st_t;

endpackage

// ----- src/lpms_cell.sv -----
// One recency position: holds the frame id sitting there, plus that frame's
// used flag and page. Entries shift toward the tail on promote.
module lpms_cell #(
  parameter int FrameIdxW = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [FrameIdxW-1:0]         reset_frame,
  input  logic                         shift_in_en,
  input  logic [FrameIdxW-1:0]         frame_in,
  input  lpms_pkg::lpms_cell_st_t      st_in,
  input  logic                         load_en,
  input  logic [FrameIdxW-1:0]         load_frame,
  input  lpms_pkg::lpms_cell_st_t      load_st,
  output logic [FrameIdxW-1:0]         frame_id,
  output lpms_pkg::lpms_cell_st_t      st
);

  logic [lpms_pkg::PageW-1:0] page;
  logic                       used;

  assign st.used = used;
  assign st.page = page;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id <= reset_frame;
      used     <= 1'b0;
    end else if (load_en) begin
      frame_id <= load_frame;
      page     <= load_st.page;
      used     <= load_st.used;
    end else if (shift_in_en) begin
      frame_id <= frame_in;
      page     <= st_in.page;
      used     <= st_in.used;
    end
  end

endmodule

// ----- src/lpms_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module lpms_divider #(
  parameter int NumW = 24,
  parameter int DenW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quot
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] n_sh;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], n_sh[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CntW'(1));
      if (start) begin
        busy <= 1'b1;
        n_sh <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CntW'(NumW);
        quot <= '0;
      end else if (busy) begin
        n_sh <= {n_sh[NumW-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
          rem  <= trial - {1'b0, d};
          quot <= {quot[NumW-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/lru_paged_memory_simulator.sv -----
// Channel | valid    | stall     | payload
// cfg     | psel/pen | pready=1  | paddr, pwdata (page_size at 0, frame_count at 4)
// in      | in_valid | in_stall  | cmd, proc_id, amount
// out     | out_valid| out_stall | status, proc_out, address, page_number, frame,
//         |          |           | evicted_page, fault_count, call_count
// Define: result after a 24-bit serial divide (for page rounding). Table full or
// bad process: result straight from idle. Invalid offset: no divide is started.
// Access: a multiply, a 24-bit serial divide, then one position scanned per cycle
// until a match at recency position k (k < frame count).
// One transaction in flight; in_stall is high until the result is taken.
// rst is synchronous; recency chain reloads to position i = frame i.
module lru_paged_memory_simulator #(
  parameter int MAX_FRAMES = lpms_pkg::MaxFramesDef,
  parameter int MAX_PROCS  = lpms_pkg::MaxProcsDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lpms_pkg::CmdW-1:0]       cmd,
  input  logic [lpms_pkg::ProcW-1:0]      proc_id,
  input  logic [lpms_pkg::AmountW-1:0]    amount,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpms_pkg::StatusW-1:0]    status,
  output logic [lpms_pkg::ProcW-1:0]      proc_out,
  output logic [lpms_pkg::AddrW-1:0]      address,
  output logic [lpms_pkg::PageW-1:0]      page_number,
  output logic [lpms_pkg::FrameW-1:0]     frame,
  output logic [lpms_pkg::PageW-1:0]      evicted_page,
  output logic [lpms_pkg::CountW-1:0]     fault_count,
  output logic [lpms_pkg::CountW-1:0]     call_count
);

  localparam int FIW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int PIW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PCW  = $clog2(MAX_PROCS + 1);
  localparam int POSW = $clog2(MAX_FRAMES + 1);
  localparam int PageW  = lpms_pkg::PageW;
  localparam int AddrW  = lpms_pkg::AddrW;
  localparam int CountW = lpms_pkg::CountW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEF_DIV, S_DEF_WAIT, S_ACC_MUL, S_ACC_DIV, S_ACC_WAIT,
    S_SCAN, S_OUT
  } state_t;

  state_t state;

  // config
  logic [lpms_pkg::PsW-1:0] page_size;
  logic [lpms_pkg::FcW-1:0] frame_count;
  logic                     wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size   <= lpms_pkg::PsW'(1);
      frame_count <= lpms_pkg::FcW'(4);
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == lpms_pkg::RegPageSize)
        page_size <= pwdata[lpms_pkg::PsW-1:0];
      else
        frame_count <= pwdata[lpms_pkg::FcW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == lpms_pkg::RegPageSize)
      prdata = {{(32-lpms_pkg::PsW){1'b0}}, page_size};
    else
      prdata = {{(32-lpms_pkg::FcW){1'b0}}, frame_count};
  end

  logic [lpms_pkg::PsW-1:0] ps;
  logic [POSW-1:0]          nfr;
  assign ps = (page_size == '0) ? lpms_pkg::PsW'(1) : page_size;
  always_comb begin
    if (frame_count == '0) nfr = POSW'(1);
    else if (32'(frame_count) > MAX_FRAMES) nfr = POSW'(MAX_FRAMES);
    else nfr = POSW'(frame_count);
  end

  // process table
  logic [PageW-1:0]                 base_mem [MAX_PROCS];
  logic [lpms_pkg::AmountW-1:0]     size_mem [MAX_PROCS];
  logic [CountW-1:0]                faults   [MAX_PROCS];
  logic [CountW-1:0]                calls    [MAX_PROCS];
  logic [PageW-1:0]                 next_free_page;
  logic [PCW-1:0]                   proc_count;

  // current transaction
  logic [PIW-1:0]               c_pid;
  logic [lpms_pkg::ProcW-1:0]   c_pid_raw;
  logic [lpms_pkg::AmountW-1:0] c_amt;
  logic [AddrW-1:0]             flat;
  logic [PageW-1:0]             c_page;
  logic [POSW-1:0]              pos;
  logic [CountW-1:0]            c_faults;
  logic [CountW-1:0]            c_calls;

  // divider
  logic            div_start, div_done;
  logic [AddrW-1:0] div_num, div_q;

  lpms_divider #(.NumW(AddrW), .DenW(lpms_pkg::PsW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(ps),
    .done(div_done), .quot(div_q)
  );

  // recency chain
  logic [FIW-1:0]             cell_frame [MAX_FRAMES];
  lpms_pkg::lpms_cell_st_t    cell_st    [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]      shift_en;
  logic [MAX_FRAMES-1:0]      load_en;
  logic [FIW-1:0]             hold_frame;
  lpms_pkg::lpms_cell_st_t    hold_st;
  lpms_pkg::lpms_cell_st_t    cur_st;
  logic [FIW-1:0]             cur_frame;

  genvar g;
  generate
    for (g = 0; g < MAX_FRAMES; g++) begin : g_cell
      if (g == 0) begin : g_head
        lpms_cell #(.FrameIdxW(FIW)) u_cell (
          .clk(clk), .rst(rst), .reset_frame(FIW'(g)),
          .shift_in_en(1'b0), .frame_in(cell_frame[g]), .st_in(cell_st[g]),
          .load_en(load_en[g]), .load_frame(hold_frame), .load_st(hold_st),
          .frame_id(cell_frame[g]), .st(cell_st[g])
        );
      end else begin : g_body
        lpms_cell #(.FrameIdxW(FIW)) u_cell (
          .clk(clk), .rst(rst), .reset_frame(FIW'(g)),
          .shift_in_en(shift_en[g]), .frame_in(cell_frame[g-1]),
          .st_in(cell_st[g-1]),
          .load_en(load_en[g]), .load_frame(hold_frame), .load_st(hold_st),
          .frame_id(cell_frame[g]), .st(cell_st[g])
        );
      end
    end
  endgenerate

  // scan reads position pos through a mux (one per cycle)
  logic [FIW-1:0] pos_idx;
  assign pos_idx = pos[FIW-1:0];
  assign cur_st    = cell_st[pos_idx];
  assign cur_frame = cell_frame[pos_idx];

  logic promote;
  logic [lpms_pkg::StatusW-1:0] p_status;
  logic [PageW-1:0]             p_evict;
  logic                         p_used_last;

  always_comb begin
    promote = 1'b0;
    p_status = lpms_pkg::StHit;
    p_evict  = '0;
    hold_st.used = 1'b1;
    hold_st.page = c_page;
    hold_frame = cur_frame;
    p_used_last = (pos == nfr - 1'b1);
    if (state == S_SCAN) begin
      if (!cur_st.used) begin
        promote = 1'b1;
        p_status = lpms_pkg::StFaultNew;
      end else if (cur_st.page == c_page) begin
        promote = 1'b1;
        p_status = lpms_pkg::StHit;
      end else if (p_used_last) begin
        promote = 1'b1;
        p_status = lpms_pkg::StFaultEv;
        p_evict = cur_st.page;
      end
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      shift_en[i] = promote && (POSW'(i) <= pos) && (i != 0);
      load_en[i]  = promote && (i == 0);
    end
  end

  // ceil(amount/ps) computed as (amount+ps-1)/ps
  logic [AddrW-1:0] def_num;
  logic [PageW:0]   np_sum;
  logic [31:0]      mul_p;
  logic [PageW-1:0] acc_page;
  assign def_num = AddrW'(c_amt) + AddrW'(ps) - AddrW'(1);
  assign np_sum = {1'b0, next_free_page} + ((div_q > AddrW'(16'hFFFF))
                  ? 17'h0FFFF : (PageW+1)'(div_q));
  assign mul_p = 32'(base_mem[c_pid]) * 32'(ps);
  // (base*ps + amount) / ps == base + amount / ps
  assign acc_page = base_mem[c_pid] + div_q[PageW-1:0];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_DEF_DIV) ||
                   (state == S_ACC_DIV && c_amt <= size_mem[c_pid]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      next_free_page <= '0;
      proc_count <= '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        faults[i] <= '0;
        calls[i]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_pid_raw <= proc_id;
            c_pid <= PIW'(proc_id);
            c_amt <= amount;
            address <= '0; page_number <= '0;
            frame <= '0; evicted_page <= '0; fault_count <= '0; call_count <= '0;
            if (cmd == lpms_pkg::CmdDefine) begin
              proc_out <= '0;
              if (32'(proc_count) >= MAX_PROCS) begin
                status <= lpms_pkg::StBadProc;
                out_valid <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_DEF_DIV;
              end
            end else if (32'(proc_id) >= 32'(proc_count)) begin
              status <= lpms_pkg::StBadProc;
              proc_out <= proc_id;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_ACC_MUL;
            end
          end
        end
        S_DEF_DIV: begin
          div_num <= def_num;
          state <= S_DEF_WAIT;
        end
        S_DEF_WAIT: begin
          if (div_done) begin
            base_mem[PIW'(proc_count)] <= next_free_page;
            size_mem[PIW'(proc_count)] <= c_amt;
            faults[PIW'(proc_count)] <= '0;
            calls[PIW'(proc_count)] <= '0;
            status <= lpms_pkg::StDefined;
            proc_out <= lpms_pkg::ProcW'(proc_count);
            address <= AddrW'(32'(next_free_page) * 32'(ps));
            page_number <= next_free_page;
            next_free_page <= np_sum[PageW] ? 16'hFFFF : np_sum[PageW-1:0];
            proc_count <= proc_count + 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_ACC_MUL: begin
          flat <= AddrW'(mul_p) + AddrW'(c_amt);
          c_calls <= (calls[c_pid] == '1) ? calls[c_pid] : calls[c_pid] + 1'b1;
          c_faults <= faults[c_pid];
          state <= S_ACC_DIV;
        end
        S_ACC_DIV: begin
          calls[c_pid] <= c_calls;
          proc_out <= c_pid_raw;
          address <= flat;
          call_count <= c_calls;
          if (c_amt > size_mem[c_pid]) begin
            status <= lpms_pkg::StInvalid;
            fault_count <= c_faults;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            div_num <= AddrW'(c_amt);
            state <= S_ACC_WAIT;
          end
        end
        S_ACC_WAIT: begin
          if (div_done) begin
            c_page <= acc_page;
            page_number <= acc_page;
            pos <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (promote) begin
            status <= p_status;
            frame <= lpms_pkg::FrameW'(cur_frame);
            evicted_page <= p_evict;
            if (p_status != lpms_pkg::StHit) begin
              c_faults <= (c_faults == '1) ? c_faults : c_faults + 1'b1;
              faults[c_pid] <= (c_faults == '1) ? c_faults : c_faults + 1'b1;
              fault_count <= (c_faults == '1) ? c_faults : c_faults + 1'b1;
            end else begin
              fault_count <= c_faults;
            end
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_lru_paged_memory_simulator.sv -----
module tb_lru_paged_memory_simulator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lpms_pkg::StatusW-1:0] status;
    logic [lpms_pkg::ProcW-1:0]   proc_out;
    logic [lpms_pkg::AddrW-1:0]   address;
    logic [lpms_pkg::PageW-1:0]   page_number;
    logic [lpms_pkg::FrameW-1:0]  frame;
    logic [lpms_pkg::PageW-1:0]   evicted_page;
    logic [lpms_pkg::CountW-1:0]  fault_count;
    logic [lpms_pkg::CountW-1:0]  call_count;
  } xlat_t;

  class xlat_scoreboard;
    int unsigned page_size = 1;
    int unsigned frame_count = 4;
    logic [lpms_pkg::PageW-1:0]   frame_page [lpms_pkg::MaxFramesDef];
    bit                           frame_used [lpms_pkg::MaxFramesDef];
    logic [lpms_pkg::FrameW-1:0]  lru_list   [lpms_pkg::MaxFramesDef];
    logic [lpms_pkg::PageW-1:0]   base_page  [lpms_pkg::MaxProcsDef];
    logic [lpms_pkg::AmountW-1:0] proc_size  [lpms_pkg::MaxProcsDef];
    logic [lpms_pkg::CountW-1:0]  faults     [lpms_pkg::MaxProcsDef];
    logic [lpms_pkg::CountW-1:0]  calls      [lpms_pkg::MaxProcsDef];
    int unsigned                  free_page = 0;
    int unsigned                  nprocs = 0;
    xlat_t                        pending [$];
    int                           errors = 0;

    function new();
      for (int i = 0; i < lpms_pkg::MaxFramesDef; i++) begin
        frame_used[i] = 0;
        lru_list[i] = lpms_pkg::FrameW'(i);
      end
      for (int i = 0; i < lpms_pkg::MaxProcsDef; i++) begin
        faults[i] = '0;
        calls[i] = '0;
      end
    endfunction

    function void to_front(int pos);
      logic [lpms_pkg::FrameW-1:0] f;
      f = lru_list[pos];
      for (int i = pos; i > 0; i--) lru_list[i] = lru_list[i-1];
      lru_list[0] = f;
    endfunction

    function void note_input(logic [lpms_pkg::CmdW-1:0] c, logic [lpms_pkg::ProcW-1:0] p,
                             logic [lpms_pkg::AmountW-1:0] a);
      xlat_t r;
      int unsigned ps, n;
      longint unsigned flat, np;
      logic [lpms_pkg::PageW-1:0] pg;
      logic [lpms_pkg::FrameW-1:0] f;
      bit done;
      r = '0;
      ps = (page_size == 0) ? 1 : page_size;
      n = (frame_count == 0) ? 1 :
          ((frame_count > lpms_pkg::MaxFramesDef) ? lpms_pkg::MaxFramesDef : frame_count);
      if (c == lpms_pkg::CmdDefine) begin
        if (nprocs >= lpms_pkg::MaxProcsDef) begin
          r.status = lpms_pkg::StBadProc;
        end else begin
          base_page[nprocs] = lpms_pkg::PageW'(free_page);
          proc_size[nprocs] = a;
          faults[nprocs] = '0;
          calls[nprocs] = '0;
          r.status = lpms_pkg::StDefined;
          r.proc_out = lpms_pkg::ProcW'(nprocs);
          r.address = lpms_pkg::AddrW'(longint'(free_page) * ps);
          r.page_number = lpms_pkg::PageW'(free_page);
          np = longint'(free_page) + (longint'(a) + ps - 1) / ps;
          free_page = (np > 16'hFFFF) ? 16'hFFFF : 32'(np);
          nprocs++;
        end
      end else if (p >= nprocs) begin
        r.status = lpms_pkg::StBadProc;
        r.proc_out = p;
      end else begin
        flat = longint'(base_page[p]) * ps + a;
        r.proc_out = p;
        r.address = lpms_pkg::AddrW'(flat);
        if (calls[p] != 16'hFFFF) calls[p]++;
        if (a > proc_size[p]) begin
          r.status = lpms_pkg::StInvalid;
        end else begin
          pg = lpms_pkg::PageW'(flat / ps);
          r.page_number = pg;
          done = 0;
          for (int pos = 0; pos < n && !done; pos++) begin
            f = lru_list[pos];
            if (!frame_used[f]) begin
              frame_used[f] = 1;
              frame_page[f] = pg;
              if (faults[p] != 16'hFFFF) faults[p]++;
              r.status = lpms_pkg::StFaultNew;
              r.frame = f;
              to_front(pos);
              done = 1;
            end else if (frame_page[f] == pg) begin
              r.status = lpms_pkg::StHit;
              r.frame = f;
              to_front(pos);
              done = 1;
            end
          end
          if (!done) begin
            f = lru_list[n-1];
            r.status = lpms_pkg::StFaultEv;
            r.frame = f;
            r.evicted_page = frame_page[f];
            frame_page[f] = pg;
            if (faults[p] != 16'hFFFF) faults[p]++;
            to_front(n - 1);
          end
        end
        r.fault_count = faults[p];
        r.call_count = calls[p];
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned g);
      if (e != g) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, g);
        errors++;
      end
    endfunction

    function void check_result(xlat_t g);
      xlat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, got %h", $time, g);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("status", e.status, g.status);
      cmp("proc_out", e.proc_out, g.proc_out);
      cmp("address", e.address, g.address);
      cmp("page_number", e.page_number, g.page_number);
      cmp("frame", e.frame, g.frame);
      cmp("evicted_page", e.evicted_page, g.evicted_page);
      cmp("fault_count", e.fault_count, g.fault_count);
      cmp("call_count", e.call_count, g.call_count);
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [lpms_pkg::CmdW-1:0] cmd;
  logic [lpms_pkg::ProcW-1:0] proc_id, proc_out;
  logic [lpms_pkg::AmountW-1:0] amount;
  logic [lpms_pkg::StatusW-1:0] status;
  logic [lpms_pkg::AddrW-1:0] address;
  logic [lpms_pkg::PageW-1:0] page_number, evicted_page;
  logic [lpms_pkg::FrameW-1:0] frame;
  logic [lpms_pkg::CountW-1:0] fault_count, call_count;

  xlat_scoreboard sb;
  int tx_idle = 0, rx_idle = 0;
  longint cycles = 0;

  lru_paged_memory_simulator i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .proc_id(proc_id), .amount(amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .proc_out(proc_out), .address(address),
    .page_number(page_number), .frame(frame), .evicted_page(evicted_page),
    .fault_count(fault_count), .call_count(call_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("tb_lru_paged_memory_simulator NOT OK");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= rst ? 1'b0 : ($urandom_range(99) < rx_idle);

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result({status, proc_out, address, page_number, frame, evicted_page,
                       fault_count, call_count});

  task automatic send(logic [lpms_pkg::CmdW-1:0] c, logic [lpms_pkg::ProcW-1:0] p,
                      logic [lpms_pkg::AmountW-1:0] a);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    proc_id <= p;
    amount <= a;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, p, a);
  endtask

  task automatic reg_write(logic [0:0] idx, logic [31:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lpms_pkg::RegPageSize) sb.page_size = data[lpms_pkg::PsW-1:0];
    else sb.frame_count = data[lpms_pkg::FcW-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned ps, sz;
    logic [lpms_pkg::ProcW-1:0] p;
    logic [lpms_pkg::AmountW-1:0] a;
    ps = (sb.page_size == 0) ? 1 : sb.page_size;
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(9))
        0: a = lpms_pkg::AmountW'($urandom);
        1: a = {lpms_pkg::AmountW{1'b1}};
        2, 3, 4: a = lpms_pkg::AmountW'($urandom_range(0, 200));
        default: a = lpms_pkg::AmountW'($urandom_range(0, 8 * ps));
      endcase
      send(lpms_pkg::CmdDefine, lpms_pkg::ProcW'($urandom), a);
    end else begin
      if (sb.nprocs == 0 || $urandom_range(99) < 5) p = lpms_pkg::ProcW'($urandom);
      else p = lpms_pkg::ProcW'($urandom_range(0, sb.nprocs - 1));
      sz = (p < sb.nprocs) ? sb.proc_size[p] : 100;
      case ($urandom_range(19))
        0, 1: a = lpms_pkg::AmountW'($urandom);
        2: a = lpms_pkg::AmountW'(sz);
        3: a = lpms_pkg::AmountW'(sz + 1);
        default: a = lpms_pkg::AmountW'($urandom_range(0, (sz > 4000) ? 4000 : sz));
      endcase
      send(lpms_pkg::CmdAccess, p, a);
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; out_stall = 0; cmd = lpms_pkg::CmdDefine; proc_id = '0; amount = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    tx_idle = 28;
    rx_idle = 58;

    send(lpms_pkg::CmdAccess, 0, 0);
    send(lpms_pkg::CmdDefine, 4'hF, 0);
    send(lpms_pkg::CmdDefine, 0, 10);
    send(lpms_pkg::CmdDefine, 0, 5);
    send(lpms_pkg::CmdAccess, 0, 0);
    send(lpms_pkg::CmdAccess, 0, 1);
    for (int i = 0; i <= 5; i++) send(lpms_pkg::CmdAccess, 1, lpms_pkg::AmountW'(i));
    send(lpms_pkg::CmdAccess, 1, 10);
    send(lpms_pkg::CmdAccess, 1, 11);
    send(lpms_pkg::CmdAccess, 1, {lpms_pkg::AmountW{1'b1}});
    send(lpms_pkg::CmdAccess, 2, 3);
    send(lpms_pkg::CmdAccess, 4'hF, 3);
    send(lpms_pkg::CmdAccess, 1, 2);
    send(lpms_pkg::CmdAccess, 1, 0);
    drain();

    for (int m = 0; m < 3; m++) begin
      if (m == 1) begin
        tx_idle = 58;
        rx_idle = 28;
      end else if (m == 2) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      for (int k = 0; k < 5; k++) begin
        case (k)
          0: begin
            reg_write(lpms_pkg::RegPageSize, 0);
            reg_write(lpms_pkg::RegFrameCount, 0);
          end
          1: begin
            reg_write(lpms_pkg::RegPageSize, 16'hFFFF);
            reg_write(lpms_pkg::RegFrameCount, 16);
          end
          2: begin
            reg_write(lpms_pkg::RegPageSize, $urandom_range(2, 20));
            reg_write(lpms_pkg::RegFrameCount, 31);
          end
          3: begin
            reg_write(lpms_pkg::RegPageSize, $urandom_range(1, 9));
            reg_write(lpms_pkg::RegFrameCount, $urandom_range(2, 15));
          end
          default: begin
            reg_write(lpms_pkg::RegPageSize, $urandom_range(0, 65535));
            reg_write(lpms_pkg::RegFrameCount, $urandom_range(0, 31));
          end
        endcase
        for (int n = 0; n < 100; n++) random_item();
        drain();
      end
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_lru_paged_memory_simulator OK");
    end else begin
      $display("tb_lru_paged_memory_simulator NOT OK");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/lpms_pkg.sv
src/lpms_cell.sv
src/lpms_divider.sv
src/lru_paged_memory_simulator.sv
tb/tb_lru_paged_memory_simulator.sv
